// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, held off while reset is asserted.
`define SLM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorted_list_merger assertion failed");

// Condition that must never be seen outside reset.
`define SLM_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sorted_list_merger forbidden condition seen");

`endif

// ===== sv/slm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_pkg
// Shared widths and interface types of the sorted list merger.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Write request from the controller to the two list memories
    typedef struct packed {
        logic              en_first;
        logic              en_second;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_wr_req;

    // One merged result handed to the output register
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
        logic              last;
        logic              overflow;
    } t_emit;

endpackage

// ===== sv/slm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_ram
// One list store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module slm_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [slm_pkg::ADDR_W-1:0] i_waddr,
    input  logic [slm_pkg::DATA_W-1:0] i_wdata,
    input  logic [slm_pkg::ADDR_W-1:0] i_raddr,
    output logic [slm_pkg::DATA_W-1:0] o_rdata
);

    logic [slm_pkg::DATA_W-1:0] r_mem [slm_pkg::LIST_DEPTH];
    logic [slm_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/slm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_ctrl
// Load sequencer and two-pointer merge over the two list memories.
// ----------------------------------------------------------------------------
module slm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_list_select,
    input  logic [slm_pkg::DATA_W-1:0] i_value,
    input  logic                       i_load_done,
    output logic                       o_in_ready,
    input  logic [slm_pkg::DATA_W-1:0] i_head_first,
    input  logic [slm_pkg::DATA_W-1:0] i_head_second,
    input  logic                       i_take,
    output slm_pkg::t_wr_req           o_wr,
    output logic [slm_pkg::ADDR_W-1:0] o_raddr_first,
    output logic [slm_pkg::ADDR_W-1:0] o_raddr_second,
    output slm_pkg::t_emit             o_emit
);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_PRIME = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;

    localparam int CW = slm_pkg::CNT_W;
    localparam logic [CW-1:0] FULL = CW'(slm_pkg::LIST_DEPTH);

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt_first, n_cnt_first;
    logic [CW-1:0] r_cnt_second, n_cnt_second;
    logic [CW-1:0] r_ptr_first, n_ptr_first;
    logic [CW-1:0] r_ptr_second, n_ptr_second;
    logic          r_ovf, n_ovf;

    logic          accept;
    logic          full_first, full_second;
    logic          left_first, left_second, pick_first;
    logic          emit_now, is_last;
    logic [CW:0]   total, emitted_next;

    always_comb begin
        o_in_ready  = (r_state == S_LOAD);
        accept      = i_in_valid && o_in_ready;
        full_first  = (r_cnt_first == FULL);
        full_second = (r_cnt_second == FULL);

        o_wr.en_first  = accept && !i_list_select && !full_first;
        o_wr.en_second = accept && i_list_select && !full_second;
        o_wr.addr      = i_list_select ? r_cnt_second[slm_pkg::ADDR_W-1:0]
                                       : r_cnt_first[slm_pkg::ADDR_W-1:0];
        o_wr.data      = i_value;

        left_first   = (r_ptr_first < r_cnt_first);
        left_second  = (r_ptr_second < r_cnt_second);
        // ties favor the first list
        pick_first   = !left_second ||
                       (left_first && ($signed(i_head_first) <= $signed(i_head_second)));
        total        = {1'b0, r_cnt_first} + {1'b0, r_cnt_second};
        emitted_next = {1'b0, r_ptr_first} + {1'b0, r_ptr_second} + (CW+1)'(1);
        is_last      = (emitted_next == total);
        emit_now     = (r_state == S_MERGE) && i_take;

        o_emit.valid    = emit_now;
        o_emit.value    = pick_first ? i_head_first : i_head_second;
        o_emit.last     = is_last;
        o_emit.overflow = r_ovf;

        n_state      = r_state;
        n_cnt_first  = r_cnt_first;
        n_cnt_second = r_cnt_second;
        n_ptr_first  = r_ptr_first;
        n_ptr_second = r_ptr_second;
        n_ovf        = r_ovf;

        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (o_wr.en_first) begin
                        n_cnt_first = r_cnt_first + CW'(1);
                    end
                    if (o_wr.en_second) begin
                        n_cnt_second = r_cnt_second + CW'(1);
                    end
                    if (!o_wr.en_first && !o_wr.en_second) begin
                        n_ovf = 1'b1;
                    end
                    if (i_load_done) begin
                        n_state = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                // head reads of entry 0 are in flight
                if (total == '0) begin
                    n_state = S_LOAD;
                    n_ovf   = 1'b0;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (emit_now) begin
                    if (pick_first) begin
                        n_ptr_first = r_ptr_first + CW'(1);
                    end else begin
                        n_ptr_second = r_ptr_second + CW'(1);
                    end
                    if (is_last) begin
                        n_state      = S_LOAD;
                        n_cnt_first  = '0;
                        n_cnt_second = '0;
                        n_ptr_first  = '0;
                        n_ptr_second = '0;
                        n_ovf        = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // read at the next pointer so the head data lines up with the pointer
        o_raddr_first  = n_ptr_first[slm_pkg::ADDR_W-1:0];
        o_raddr_second = n_ptr_second[slm_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_cnt_first  <= '0;
            r_cnt_second <= '0;
            r_ptr_first  <= '0;
            r_ptr_second <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_first  <= n_cnt_first;
            r_cnt_second <= n_cnt_second;
            r_ptr_first  <= n_ptr_first;
            r_ptr_second <= n_ptr_second;
            r_ovf        <= n_ovf;
        end
    end

endmodule

// ===== sv/sorted_list_merger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_merger
// Loads two ascending lists and streams their merge in ascending order.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): one element per request, tagged by
// i_list_select. Elements are stored at one per cycle while o_in_ready is high; an element for a list
// already holding 32 entries is dropped and flagged. The request with
// i_load_done high stores its element and starts the merge.
// Output channel (o_out_valid / i_out_ready): one merged element per request,
// o_last_out on the final one, o_overflow on all of them when anything was
// dropped. Ties give the first list's element first.
// Timing: after the load_done request come the memory write and then the head
// read in the prime state before the first result is registered; then one result
// per cycle while the output does not stall, from registered memory reads. Input is
// refused from load_done until the last result is registered; the next load
// may then start while that result still waits in the output register.
// A stall on the output holds the merge pointers and the output register.
// Reset empties both lists and clears the overflow flag and output valid.
// ----------------------------------------------------------------------------
module sorted_list_merger (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_list_select,
    input  logic [slm_pkg::DATA_W-1:0] i_value,
    input  logic                       i_load_done,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [slm_pkg::DATA_W-1:0] o_merged_value,
    output logic                       o_last_out,
    output logic                       o_overflow
);

    slm_pkg::t_wr_req           wr;
    slm_pkg::t_emit             emit;
    logic [slm_pkg::ADDR_W-1:0] raddr_first, raddr_second;
    logic [slm_pkg::DATA_W-1:0] head_first, head_second;
    logic                       take;

    logic                       r_out_valid;
    logic [slm_pkg::DATA_W-1:0] r_out_value;
    logic                       r_out_last;
    logic                       r_out_ovf;

    assign take = !r_out_valid || i_out_ready;

    slm_ram u_first_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en_first),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr_first),
        .o_rdata (head_first)
    );

    slm_ram u_second_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en_second),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr_second),
        .o_rdata (head_second)
    );

    slm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_list_select  (i_list_select),
        .i_value        (i_value),
        .i_load_done    (i_load_done),
        .o_in_ready     (o_in_ready),
        .i_head_first   (head_first),
        .i_head_second  (head_second),
        .i_take         (take),
        .o_wr           (wr),
        .o_raddr_first  (raddr_first),
        .o_raddr_second (raddr_second),
        .o_emit         (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out_value <= emit.value;
            r_out_last  <= emit.last;
            r_out_ovf   <= emit.overflow;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_value;
    assign o_last_out     = r_out_last;
    assign o_overflow     = r_out_ovf;

endmodule

// ===== sv/slm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_checker
// Port-level checks of the sorted list merger, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       i_load_done,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [slm_pkg::DATA_W-1:0] o_merged_value,
    input logic                       o_last_out
);

    // a stalled result holds
    `SLM_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_merged_value)))

    // the closing load request locks out input for the merge
    `SLM_ASSERT(a_done_locks, i_clk, i_rst_n,
        (i_in_valid && o_in_ready && i_load_done) |=> !o_in_ready)

    // an ordinary load request keeps input open
    `SLM_ASSERT(a_load_open, i_clk, i_rst_n,
        (i_in_valid && o_in_ready && !i_load_done) |=> o_in_ready)

    // a non-final result means the merge is still running
    `SLM_NEVER(a_mid_merge_closed, i_clk, i_rst_n,
        o_out_valid && !o_last_out && o_in_ready)

endmodule

bind sorted_list_merger slm_checker u_slm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_load_done    (i_load_done),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_merged_value (o_merged_value),
    .o_last_out     (o_last_out)
);
